[rtl/rxrb_pkg.sv]
package rxrb_pkg;

    localparam int DEPTH   = 64;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int DELIV_W = 6;

    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_GET   = 2'd1,
        FUNC_DRAIN = 2'd2,
        FUNC_POLL  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESP,
        ST_STREAM
    } state_t;

    typedef struct packed {
        logic             wr_en;
        logic [PTR_W-1:0] wr_addr;
        logic             rd_en;
        logic [PTR_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic               strobe;
        logic               has_byte;
        logic               last;
        logic [DELIV_W-1:0] delivered;
    } res_ctrl_t;

endpackage

[rtl/rxrb_ctrl.sv]
module rxrb_ctrl
    import rxrb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] func,
    output logic       busy,
    output mem_req_t   mem,
    output res_ctrl_t  res
);

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [PTR_W-1:0]   prev_reg, prev_next;
    logic               all_reg, all_next;
    logic [DELIV_W-1:0] sent_reg, sent_next;

    func_t              fn;
    logic               accept;
    logic               empty;
    logic               quiet;
    logic [PTR_W-1:0]   wp_adv;
    logic [PTR_W-1:0]   rp_adv;
    logic [PTR_W:0]     count_wide;
    logic [PTR_W-1:0]   count;
    logic               more;

    assign fn     = func_t'(func);
    assign accept = start && (state_reg == ST_IDLE);
    assign empty  = (wp_reg == rp_reg);
    assign wp_adv = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_adv = (rp_reg == PTR_W'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign count_wide = (wp_reg >= rp_reg)
        ? {1'b0, wp_reg} - {1'b0, rp_reg}
        : {1'b0, wp_reg} + (PTR_W+1)'(DEPTH) - {1'b0, rp_reg};
    assign count  = count_wide[PTR_W-1:0];
    assign quiet  = (count == prev_reg);
    assign more   = all_reg && !empty;
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (fn)
                        FUNC_PUSH:  state_next = ST_IDLE;
                        FUNC_GET:   state_next = empty ? ST_RESP : ST_STREAM;
                        FUNC_DRAIN: state_next = empty ? ST_RESP : ST_STREAM;
                        FUNC_POLL:  state_next = (!quiet || empty) ? ST_RESP : ST_STREAM;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RESP:   state_next = ST_IDLE;
            ST_STREAM: state_next = more ? ST_STREAM : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        prev_next   = prev_reg;
        all_next    = all_reg;
        sent_next   = sent_reg;
        mem.wr_en   = 1'b0;
        mem.wr_addr = wp_reg;
        mem.rd_en   = 1'b0;
        mem.rd_addr = rp_reg;
        if (accept)
        begin
            sent_next = '0;
            all_next  = (fn != FUNC_GET);
            case (fn) inside
                FUNC_PUSH:
                begin
                    mem.wr_en = 1'b1;
                    if (wp_adv != rp_reg)
                    begin
                        wp_next = wp_adv;
                    end
                end
                FUNC_GET, FUNC_DRAIN:
                begin
                    mem.rd_en = !empty;
                end
                default:
                begin
                    if (quiet)
                    begin
                        mem.rd_en = !empty;
                    end
                    else
                    begin
                        prev_next = count;
                    end
                end
            endcase
        end
        if (state_reg == ST_STREAM)
        begin
            sent_next = sent_reg + 1'b1;
            mem.rd_en = more;
        end
        if (mem.rd_en)
        begin
            rp_next = rp_adv;
        end
    end

    always_comb
    begin
        res.strobe    = (state_reg == ST_RESP) || (state_reg == ST_STREAM);
        res.has_byte  = (state_reg == ST_STREAM);
        res.last      = (state_reg == ST_RESP) || !more;
        res.delivered = (state_reg == ST_STREAM) ? sent_reg + 1'b1 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            rp_reg    <= '0;
            prev_reg  <= '0;
            all_reg   <= 1'b0;
            sent_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            prev_reg  <= prev_next;
            all_reg   <= all_next;
            sent_reg  <= sent_next;
        end
    end

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg <= PTR_W'(DEPTH - 1)) && (rp_reg <= PTR_W'(DEPTH - 1)))
        else $error("pointer out of range");

    a_get_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fn == FUNC_GET) |=> (res.strobe && res.last))
        else $error("get request without a single final result");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (res.strobe && res.last) |=> !busy)
        else $error("still busy after final result");

    a_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (res.strobe && !res.has_byte) |-> (res.last && res.delivered == '0))
        else $error("empty result not final");

    a_read_streams: assert property (@(posedge clk) disable iff (!rst_n)
        mem.rd_en |=> (state_reg == ST_STREAM))
        else $error("read issued with no result to follow");

endmodule

[rtl/rx_ring_buffer_frame_poll.sv]
// Channel   Handshake              Fields
// request   start & !busy          func[1:0], byte_in[7:0]
// result    strobe (one cycle)     byte_out[7:0], has_byte, last, delivered[5:0]
//
// A push never raises busy.
// Get, drain and poll give their first result in the cycle after the request, as
// the byte store's read port is registered; a drain or quiet poll then gives one
// byte a cycle, with busy high until the last.
// Reset clears the pointers and the poll count; the byte store is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module rx_ring_buffer_frame_poll
    import rxrb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [7:0]         byte_in,
    output logic               strobe,
    output logic [7:0]         byte_out,
    output logic               has_byte,
    output logic               last,
    output logic [DELIV_W-1:0] delivered
);

    mem_req_t   mem;
    res_ctrl_t  res;
    logic [7:0] store_reg [DEPTH];
    logic [7:0] rd_data_reg;

    rxrb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .busy  (busy),
        .mem   (mem),
        .res   (res)
    );

    always_ff @(posedge clk)
    begin
        if (mem.wr_en)
        begin
            store_reg[mem.wr_addr] <= byte_in;
        end
        if (mem.rd_en)
        begin
            rd_data_reg <= store_reg[mem.rd_addr];
        end
    end

    assign strobe    = res.strobe;
    assign has_byte  = res.has_byte;
    assign last      = res.last;
    assign delivered = res.delivered;
    assign byte_out  = res.has_byte ? rd_data_reg : 8'd0;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import rxrb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 170;

    typedef struct {
        logic [7:0]         data;
        logic               has;
        logic               fin;
        logic [DELIV_W-1:0] count;
    } rx_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         func = FUNC_PUSH;
    logic [7:0]         byte_in = 8'h00;
    logic               strobe;
    logic [7:0]         byte_out;
    logic               has_byte;
    logic               last;
    logic [DELIV_W-1:0] delivered;

    logic [7:0]  rx_bytes [DEPTH];
    int          wr_ptr = 0;
    int          rd_ptr = 0;
    int          last_poll_count = 0;
    rx_result_t  expected_results [$];

    int          mismatches = 0;
    int          cycles = 0;
    int          requests_sent = 0;
    bit          gaps_enabled = 1'b1;

    rx_ring_buffer_frame_poll dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .byte_in   (byte_in),
        .strobe    (strobe),
        .byte_out  (byte_out),
        .has_byte  (has_byte),
        .last      (last),
        .delivered (delivered)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int next_slot(input int p);
        return (p + 1 == DEPTH) ? 0 : p + 1;
    endfunction

    function automatic void add_result(input logic [7:0] d, input logic h, input logic f,
                                       input int n);
        rx_result_t r;
        r.data  = d;
        r.has   = h;
        r.fin   = f;
        r.count = n[DELIV_W-1:0];
        expected_results.push_back(r);
    endfunction

    function automatic void unload_buffer();
        int sent;
        logic [7:0] b;
        sent = 0;
        while (rd_ptr != wr_ptr)
        begin
            b = rx_bytes[rd_ptr];
            rd_ptr = next_slot(rd_ptr);
            sent++;
            add_result(b, 1'b1, rd_ptr == wr_ptr, sent);
        end
        if (sent == 0)
            add_result(8'h00, 1'b0, 1'b1, 0);
    endfunction

    function automatic void model_request(input func_t f, input logic [7:0] b);
        int n;
        int fill;
        case (f)
            FUNC_PUSH:
            begin
                rx_bytes[wr_ptr] = b;
                n = next_slot(wr_ptr);
                if (n != rd_ptr)
                    wr_ptr = n;
            end
            FUNC_GET:
            begin
                if (rd_ptr == wr_ptr)
                    add_result(8'h00, 1'b0, 1'b1, 0);
                else
                begin
                    add_result(rx_bytes[rd_ptr], 1'b1, 1'b1, 1);
                    rd_ptr = next_slot(rd_ptr);
                end
            end
            FUNC_DRAIN:
                unload_buffer();
            FUNC_POLL:
            begin
                fill = (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + DEPTH - rd_ptr;
                if (fill != last_poll_count)
                begin
                    last_poll_count = fill;
                    add_result(8'h00, 1'b0, 1'b1, 0);
                end
                else
                    unload_buffer();
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycles, what);
        mismatches++;
    endtask

    // check results and predict accepted requests on the same edge
    always @(posedge clk)
    begin
        rx_result_t e;
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
        if (rst_n && strobe)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result byte_out=%02h", byte_out));
            else
            begin
                e = expected_results.pop_front();
                if (byte_out !== e.data)
                    report_mismatch($sformatf("byte_out %02h, want %02h", byte_out, e.data));
                if (has_byte !== e.has)
                    report_mismatch($sformatf("has_byte %b, want %b", has_byte, e.has));
                if (last !== e.fin)
                    report_mismatch($sformatf("last %b, want %b", last, e.fin));
                if (delivered !== e.count)
                    report_mismatch($sformatf("delivered %0d, want %0d", delivered, e.count));
            end
        end
        if (rst_n && start && !busy)
            model_request(func_t'(func), byte_in);
    end

    task automatic send_request(input func_t f, input logic [7:0] b);
        if (gaps_enabled && $urandom_range(99) < 8)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start   <= 1'b1;
        func    <= f;
        byte_in <= b;
        do
            @(posedge clk);
        while (busy);
        requests_sent++;
    endtask

    task automatic push_bytes(input int n);
        repeat (n) send_request(FUNC_PUSH, 8'($urandom));
    endtask

    task automatic test_empty_requests();
        send_request(FUNC_GET, 8'h00);
        send_request(FUNC_DRAIN, 8'h00);
        send_request(FUNC_POLL, 8'hFF);
    endtask

    task automatic test_single_bytes();
        send_request(FUNC_PUSH, 8'h00);
        send_request(FUNC_PUSH, 8'hFF);
        send_request(FUNC_GET, 8'hFF);
        send_request(FUNC_GET, 8'h00);
        send_request(FUNC_GET, 8'h00);
    endtask

    task automatic test_drain();
        send_request(FUNC_PUSH, 8'h81);
        send_request(FUNC_PUSH, 8'h7E);
        send_request(FUNC_PUSH, 8'h01);
        send_request(FUNC_DRAIN, 8'h00);
        send_request(FUNC_DRAIN, 8'h00);
    endtask

    task automatic test_frame_poll();
        send_request(FUNC_PUSH, 8'h12);
        send_request(FUNC_PUSH, 8'hED);
        send_request(FUNC_POLL, 8'h00);
        send_request(FUNC_POLL, 8'h00);
        send_request(FUNC_POLL, 8'h00);
        send_request(FUNC_POLL, 8'h00);
        send_request(FUNC_PUSH, 8'h55);
        send_request(FUNC_POLL, 8'h00);
        send_request(FUNC_PUSH, 8'hAA);
        send_request(FUNC_POLL, 8'h00);
        send_request(FUNC_DRAIN, 8'h00);
        send_request(FUNC_POLL, 8'h00);
    endtask

    task automatic test_overflow();
        gaps_enabled = 1'b0;
        push_bytes(66);
        send_request(FUNC_POLL, 8'h00);
        send_request(FUNC_POLL, 8'h00);
        push_bytes(40);
        send_request(FUNC_DRAIN, 8'h00);
        gaps_enabled = 1'b1;
    endtask

    task automatic test_random_traffic();
        int pick;
        int target;
        target = requests_sent + RANDOM_ITEMS;
        while (requests_sent < target)
        begin
            gaps_enabled = !(requests_sent > target - 200 && requests_sent < target - 120);
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                // one received frame followed by polls until it is taken
                push_bytes(($urandom_range(9) == 0) ? $urandom_range(40, 70)
                                                    : $urandom_range(0, 12));
                send_request(FUNC_POLL, 8'($urandom));
                if ($urandom_range(3) == 0)
                begin
                    push_bytes($urandom_range(1, 3));
                    send_request(FUNC_POLL, 8'($urandom));
                end
                send_request(FUNC_POLL, 8'($urandom));
            end
            else if (pick < 75)
            begin
                push_bytes($urandom_range(0, 6));
                repeat ($urandom_range(1, 5)) send_request(FUNC_GET, 8'($urandom));
            end
            else if (pick < 85)
            begin
                push_bytes($urandom_range(0, 20));
                send_request(FUNC_DRAIN, 8'($urandom));
            end
            else
                repeat ($urandom_range(1, 8)) send_request(func_t'($urandom_range(3)),
                                                           8'($urandom));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_requests();
        test_single_bytes();
        test_drain();
        test_frame_poll();
        test_overflow();
        test_random_traffic();

        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
